>>> rtl/assert_macros.svh
// assertion helpers, compiled out when ASSERT_OFF is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SRE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define SRE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SRE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SRE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/sre_pkg.sv
`default_nettype none
package sre_pkg;
   localparam int IN_W    = 16;
   localparam int VEC     = 3;
   localparam int RAD_W   = 16;
   localparam int SQ_W    = 32;
   localparam int ROOT_W  = 32;
   localparam int REM_W   = ROOT_W + 3;
   localparam int Q_W     = 17;
   localparam int DEN_W   = ROOT_W + 1;
   localparam int NUM_W   = DEN_W + Q_W;
   localparam int PT_W    = 17;
   localparam int HD_W    = 16;
   localparam int PROD_W  = PT_W + HD_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int REQ_W   = 2 * VEC * IN_W;
   localparam int RSP_W   = 152;
   localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd256;
   localparam logic [Q_W-1:0]   HEAD_MAX     = 17'd32767;

   typedef struct packed {
      logic                     deg;
      logic [VEC-1:0]           sgn_p;
      logic [VEC-1:0]           sgn_d;
      logic [VEC-1:0][IN_W-1:0] ap;
      logic [VEC-1:0][IN_W-1:0] ad;
   } sq_side_type;

   typedef struct packed {
      logic           deg;
      logic [VEC-1:0] sgn_p;
      logic [VEC-1:0] sgn_d;
   } div_side_type;

   localparam int SQ_SIDE_W  = $bits(sq_side_type);
   localparam int DIV_SIDE_W = $bits(div_side_type);
endpackage
`default_nettype wire

>>> rtl/sre_isqrt.sv
`default_nettype none
// pipelined integer square root of rad * 2^SQ_W, one root bit per stage
module sre_isqrt import sre_pkg::*; #(
   parameter int LANES  = 2,
   parameter int SIDE_W = SQ_SIDE_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [SQ_W-1:0]   in_rad [LANES],
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [ROOT_W-1:0]      out_root [LANES],
   output logic [SIDE_W-1:0]      out_side
);
   localparam int STEPS = ROOT_W;

   logic [REM_W-1:0]  st_rem  [STEPS+1][LANES];
   logic [ROOT_W-1:0] st_root [STEPS+1][LANES];
   logic [SQ_W-1:0]   st_rad  [STEPS+1][LANES];
   logic [SIDE_W-1:0] st_side [STEPS+1];
   logic              st_vld  [STEPS+1];

   assign st_side[0] = in_side;
   assign st_vld[0]  = in_valid;

   for (genvar l = 0; l < LANES; l++) begin : g_in
      assign st_rem[0][l]  = '0;
      assign st_root[0][l] = '0;
      assign st_rad[0][l]  = in_rad[l];
      assign out_root[l]   = st_root[STEPS][l];
   end

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic              vld_ff;
      logic [SIDE_W-1:0] side_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= st_vld[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff <= st_side[j];
         end
      end

      assign st_vld[j+1]  = vld_ff;
      assign st_side[j+1] = side_ff;

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [REM_W-1:0]  cur, trial, rem_in, rem_ff;
         logic [ROOT_W-1:0] root_in, root_ff;
         logic [SQ_W-1:0]   rad_ff;

         always_comb begin
            cur   = {st_rem[j][l][REM_W-3:0], st_rad[j][l][SQ_W-1 -: 2]};
            trial = REM_W'({st_root[j][l], 2'b01});
            if (cur >= trial) begin
               rem_in  = cur - trial;
               root_in = {st_root[j][l][ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = cur;
               root_in = {st_root[j][l][ROOT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff  <= rem_in;
               root_ff <= root_in;
               rad_ff  <= {st_rad[j][l][SQ_W-3:0], 2'b00};
            end
         end

         assign st_rem[j+1][l]  = rem_ff;
         assign st_root[j+1][l] = root_ff;
         assign st_rad[j+1][l]  = rad_ff;
      end
   end

   assign out_valid = st_vld[STEPS];
   assign out_side  = st_side[STEPS];
endmodule
`default_nettype wire

>>> rtl/sre_div.sv
`default_nettype none
// pipelined restoring divider, one quotient bit per stage
module sre_div import sre_pkg::*; #(
   parameter int LANES  = 2 * VEC,
   parameter int SIDE_W = DIV_SIDE_W
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num [LANES],
   input  wire logic [DEN_W-1:0]  in_den [LANES],
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [Q_W-1:0]         out_quot [LANES],
   output logic [SIDE_W-1:0]      out_side
);
   logic [NUM_W-1:0]  st_rem  [Q_W+1][LANES];
   logic [DEN_W-1:0]  st_den  [Q_W+1][LANES];
   logic [Q_W-1:0]    st_quot [Q_W+1][LANES];
   logic [SIDE_W-1:0] st_side [Q_W+1];
   logic              st_vld  [Q_W+1];

   assign st_side[0] = in_side;
   assign st_vld[0]  = in_valid;

   for (genvar l = 0; l < LANES; l++) begin : g_in
      assign st_rem[0][l]  = in_num[l];
      assign st_den[0][l]  = in_den[l];
      assign st_quot[0][l] = '0;
      assign out_quot[l]   = st_quot[Q_W][l];
   end

   for (genvar j = 0; j < Q_W; j++) begin : g_step
      logic              vld_ff;
      logic [SIDE_W-1:0] side_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= st_vld[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff <= st_side[j];
         end
      end

      assign st_vld[j+1]  = vld_ff;
      assign st_side[j+1] = side_ff;

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [NUM_W-1:0] sub, rem_in, rem_ff;
         logic [Q_W-1:0]   quot_in, quot_ff;
         logic [DEN_W-1:0] den_ff;

         always_comb begin
            sub = NUM_W'(st_den[j][l]) << (Q_W - 1 - j);
            if (st_rem[j][l] >= sub) begin
               rem_in  = st_rem[j][l] - sub;
               quot_in = {st_quot[j][l][Q_W-2:0], 1'b1};
            end else begin
               rem_in  = st_rem[j][l];
               quot_in = {st_quot[j][l][Q_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff  <= rem_in;
               quot_ff <= quot_in;
               den_ff  <= st_den[j][l];
            end
         end

         assign st_rem[j+1][l]  = rem_ff;
         assign st_quot[j+1][l] = quot_ff;
         assign st_den[j+1][l]  = den_ff;
      end
   end

   assign out_valid = st_vld[Q_W];
   assign out_side  = st_side[Q_W];
endmodule
`default_nettype wire

>>> rtl/sphere_ray_emitter.sv
// sphere_ray_emitter: turns each request word of six Q1.15 randoms into one ray on the
// surface of a sphere of radius csr_data (8 fraction bits, 256 = 1.0, reset 256). The
// position randoms are scaled to length radius (point, also sent as the surface normal),
// the direction randoms are normalized to a Q1.15 unit vector and flipped if it points
// inward. An all-zero position or direction gives zero vectors with the degenerate flag
// in rsp_tuser. One word is taken every cycle as long as the response side keeps up. The
// pipe is built from the 32-stage square root (one root bit per stage), the 17-stage
// divider (one quotient bit per stage) and seven data stages. The whole pipe holds
// while a response word waits. Write the radius only while the block is idle.
`default_nettype none
`include "assert_macros.svh"
module sphere_ray_emitter import sre_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   // radius register write
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [RAD_W-1:0] csr_data,
   // pos_rand_x, pos_rand_y, pos_rand_z, dir_rand_x, dir_rand_y, dir_rand_z
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   // point_x/y/z, heading_x/y/z, surface_normal_x/y/z, then two pad bits
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   // degenerate
   output logic [0:0]            rsp_tuser
);
   // global advance: the pipe moves when the output slot is free or being drained
   logic en;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // radius register
   logic [RAD_W-1:0] radius_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         radius_ff <= csr_data;
      end
   end

   // stage 1: capture request word
   logic                   v1_ff;
   logic signed [IN_W-1:0] p1_ff [VEC];
   logic signed [IN_W-1:0] d1_ff [VEC];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < VEC; i++) begin
            p1_ff[i] <= $signed(req_tdata[i*IN_W +: IN_W]);
            d1_ff[i] <= $signed(req_tdata[(VEC+i)*IN_W +: IN_W]);
         end
      end
   end

   // stage 2: squared lengths, magnitudes and signs
   logic        [SQ_W-1:0] sp_in, sd_in, sp2_ff, sd2_ff;
   sq_side_type            side2_in, side2_ff;
   logic                   v2_ff;

   always_comb begin
      sp_in = '0;
      sd_in = '0;
      for (int i = 0; i < VEC; i++) begin
         sp_in = sp_in + SQ_W'(p1_ff[i] * p1_ff[i]);
         sd_in = sd_in + SQ_W'(d1_ff[i] * d1_ff[i]);
         side2_in.sgn_p[i] = p1_ff[i][IN_W-1];
         side2_in.sgn_d[i] = d1_ff[i][IN_W-1];
         side2_in.ap[i]    = p1_ff[i][IN_W-1] ? IN_W'(-p1_ff[i]) : IN_W'(p1_ff[i]);
         side2_in.ad[i]    = d1_ff[i][IN_W-1] ? IN_W'(-d1_ff[i]) : IN_W'(d1_ff[i]);
      end
      // zero vector: no direction to scale
      side2_in.deg = (p1_ff[0] == 0 && p1_ff[1] == 0 && p1_ff[2] == 0) ||
                     (d1_ff[0] == 0 && d1_ff[1] == 0 && d1_ff[2] == 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sp2_ff   <= sp_in;
         sd2_ff   <= sd_in;
         side2_ff <= side2_in;
      end
   end

   // square roots: lane 0 is the position length, lane 1 the direction length
   logic [SQ_W-1:0]      sq_rad  [2];
   logic [ROOT_W-1:0]    sq_root [2];
   logic [SQ_SIDE_W-1:0] sq_side_out;
   logic                 sq_valid;
   sq_side_type          sq_side;

   assign sq_rad[0] = sp2_ff;
   assign sq_rad[1] = sd2_ff;

   sre_isqrt #(
      .LANES  (2),
      .SIDE_W (SQ_SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v2_ff),
      .in_rad    (sq_rad),
      .in_side   (side2_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_out)
   );

   assign sq_side = sq_side_type'(sq_side_out);

   // stage 3: scale position magnitudes by radius
   logic                  v3_ff;
   logic [2*RAD_W-1:0]    mp3_ff [VEC];
   logic [IN_W-1:0]       ad3_ff [VEC];
   logic [ROOT_W-1:0]     lp3_ff, ld3_ff;
   div_side_type          dside3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < VEC; i++) begin
            mp3_ff[i] <= sq_side.ap[i] * radius_ff;
            ad3_ff[i] <= sq_side.ad[i];
         end
         lp3_ff          <= sq_root[0];
         ld3_ff          <= sq_root[1];
         dside3_ff.deg   <= sq_side.deg;
         dside3_ff.sgn_p <= sq_side.sgn_p;
         dside3_ff.sgn_d <= sq_side.sgn_d;
      end
   end

   // stage 4: dividends (M << 17) + L (point) and (A << 32) + L (heading), divisors 2*L, round to nearest
   logic                 v4_ff;
   logic [NUM_W-1:0]     num4_ff [2*VEC];
   logic [DEN_W-1:0]     den4_ff [2*VEC];
   div_side_type         dside4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < VEC; i++) begin
            num4_ff[i]     <= (NUM_W'(mp3_ff[i]) << Q_W) + NUM_W'(lp3_ff);
            den4_ff[i]     <= {lp3_ff, 1'b0};
            num4_ff[VEC+i] <= (NUM_W'(ad3_ff[i]) << ROOT_W) + NUM_W'(ld3_ff);
            den4_ff[VEC+i] <= {ld3_ff, 1'b0};
         end
         dside4_ff <= dside3_ff;
      end
   end

   // dividers: lanes 0..2 point, lanes 3..5 heading
   logic [Q_W-1:0]        quot [2*VEC];
   logic [DIV_SIDE_W-1:0] dv_side_out;
   logic                  dv_valid;
   div_side_type          dv_side;

   sre_div #(
      .LANES  (2 * VEC),
      .SIDE_W (DIV_SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_num    (num4_ff),
      .in_den    (den4_ff),
      .in_side   (dside4_ff),
      .out_valid (dv_valid),
      .out_quot  (quot),
      .out_side  (dv_side_out)
   );

   assign dv_side = div_side_type'(dv_side_out);

   // stage 5: restore signs, saturate heading
   logic                   v5_ff, deg5_ff;
   logic signed [PT_W-1:0] pt5_ff [VEC];
   logic signed [HD_W-1:0] hd5_ff [VEC];
   logic        [HD_W-1:0] hmag   [VEC];

   always_comb begin
      for (int i = 0; i < VEC; i++) begin
         hmag[i] = (quot[VEC+i] > HEAD_MAX) ? HD_W'(HEAD_MAX) : HD_W'(quot[VEC+i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < VEC; i++) begin
            pt5_ff[i] <= dv_side.sgn_p[i] ? -$signed(quot[i]) : $signed(quot[i]);
            hd5_ff[i] <= dv_side.sgn_d[i] ? -$signed(hmag[i]) : $signed(hmag[i]);
         end
         deg5_ff <= dv_side.deg;
      end
   end

   // stage 6: dot product terms
   logic                     v6_ff, deg6_ff;
   logic signed [PROD_W-1:0] prod6_ff [VEC];
   logic signed [PT_W-1:0]   pt6_ff   [VEC];
   logic signed [HD_W-1:0]   hd6_ff   [VEC];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < VEC; i++) begin
            prod6_ff[i] <= pt5_ff[i] * hd5_ff[i];
            pt6_ff[i]   <= pt5_ff[i];
            hd6_ff[i]   <= hd5_ff[i];
         end
         deg6_ff <= deg5_ff;
      end
   end

   // stage 7: outward flip, degenerate override, output register
   logic signed [DOT_W-1:0] dot;
   logic signed [PT_W-1:0]  pt7_ff [VEC];
   logic signed [HD_W-1:0]  hd7_ff [VEC];
   logic                    deg7_ff;

   assign dot = DOT_W'(prod6_ff[0]) + DOT_W'(prod6_ff[1]) + DOT_W'(prod6_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < VEC; i++) begin
            if (deg6_ff) begin
               pt7_ff[i] <= '0;
               hd7_ff[i] <= '0;
            end else begin
               pt7_ff[i] <= pt6_ff[i];
               hd7_ff[i] <= dot[DOT_W-1] ? -hd6_ff[i] : hd6_ff[i];
            end
         end
         deg7_ff <= deg6_ff;
      end
   end

   // response word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = deg7_ff;
   assign rsp_tdata  = {2'b00,
                        pt7_ff[2], pt7_ff[1], pt7_ff[0],
                        hd7_ff[2], hd7_ff[1], hd7_ff[0],
                        pt7_ff[2], pt7_ff[1], pt7_ff[0]};

   // checks
   `SRE_ASSERT_IMPL(a_deg_zero, clock, reset, rsp_valid_ff && deg7_ff, (pt7_ff[0] == 0) && (pt7_ff[1] == 0) && (pt7_ff[2] == 0) && (hd7_ff[0] == 0))
   `SRE_ASSERT_IMPL(a_head_sat, clock, reset, rsp_valid_ff, (hd7_ff[0] != {1'b1, 15'd0}) && (hd7_ff[1] != {1'b1, 15'd0}) && (hd7_ff[2] != {1'b1, 15'd0}))
   `SRE_ASSERT_IMPL(a_pt_bound, clock, reset, rsp_valid_ff, (pt7_ff[0] <= $signed({1'b0, radius_ff})) && (pt7_ff[0] >= -$signed({1'b0, radius_ff})))
   `SRE_ASSERT_NEXT(a_csr_wr, clock, reset, csr_valid, radius_ff == $past(csr_data))
endmodule
`default_nettype wire
